### rtl/bpfa_pkg.sv
package bpfa_pkg;

    localparam int ADDR_W = 64;
    localparam int SIZE_W = 32;
    localparam int CNT_W  = 13;
    localparam int OP_W   = 3;
    localparam int CFG_W  = 2;

    localparam int DEF_MAX_PAGES     = 4096;
    localparam int DEF_MAP_WORD_BITS = 32;

    localparam logic [CNT_W-1:0]  PAGE_COUNT_RESET = 13'd4096;
    localparam logic [ADDR_W-1:0] BASE_RESET       = 64'd0;
    localparam logic [SIZE_W-1:0] SIZE_RESET       = 32'd4096;

    localparam logic [OP_W-1:0] OP_ALLOC_PAGE = 3'd0;
    localparam logic [OP_W-1:0] OP_ALLOC_RUN  = 3'd1;
    localparam logic [OP_W-1:0] OP_FREE_PAGE  = 3'd2;
    localparam logic [OP_W-1:0] OP_RESERVE    = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

    localparam logic [CFG_W-1:0] REG_PAGE_COUNT = 2'd0;
    localparam logic [CFG_W-1:0] REG_BASE_ADDR  = 2'd1;
    localparam logic [CFG_W-1:0] REG_PAGE_SIZE  = 2'd2;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DIV  = 8'b0000_0010,
        S_RD   = 8'b0000_0100,
        S_EXAM = 8'b0000_1000,
        S_SCAN = 8'b0001_0000,
        S_MUL  = 8'b0010_0000,
        S_ADD  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

endpackage

### rtl/bitmap_page_frame_allocator_unit.sv
// channel  direction  handshake            payload
// cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
// in       in         in_valid/in_ready    operation, addr, count
// out      out        out_valid/out_ready  page_address, granted, allocated, free_left
//
// one request at a time; in_ready and cfg_ready are high only while idle
// free, reserve and query first pass through the bit-serial divider, then read map words
// alloc page reads map words until one holds a free page; alloc run scans one page bit per
// cycle, pausing to read each map word, and then marks the run word by word
// reset and a page_count write clear the map at once through per-word valid bits
// a stalled result holds in the output register; the next request then waits in done
module bitmap_page_frame_allocator_unit #(
    parameter int MAX_PAGES     = bpfa_pkg::DEF_MAX_PAGES,
    parameter int MAP_WORD_BITS = bpfa_pkg::DEF_MAP_WORD_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bpfa_pkg::CFG_W-1:0]    cfg_index,
    input  logic [bpfa_pkg::ADDR_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bpfa_pkg::OP_W-1:0]     operation,
    input  logic [bpfa_pkg::ADDR_W-1:0]   addr,
    input  logic [bpfa_pkg::CNT_W-1:0]    count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bpfa_pkg::ADDR_W-1:0]   page_address,
    output logic                          granted,
    output logic                          allocated,
    output logic [bpfa_pkg::CNT_W-1:0]    free_left
);

    localparam int AW    = bpfa_pkg::ADDR_W;
    localparam int SW    = bpfa_pkg::SIZE_W;
    localparam int CW    = bpfa_pkg::CNT_W;
    localparam int WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BI_W  = $clog2(MAP_WORD_BITS);
    localparam int IDX_W = $clog2(WORDS * MAP_WORD_BITS);
    localparam int CMP_W = ((IDX_W > CW) ? IDX_W : CW) + 2;
    localparam int PW    = IDX_W + SW;
    localparam logic [CW-1:0] PC_RESET =
        (int'(bpfa_pkg::PAGE_COUNT_RESET) > MAX_PAGES) ? CW'(MAX_PAGES)
                                                       : bpfa_pkg::PAGE_COUNT_RESET;

    bpfa_pkg::state_t state_reg, state_next;

    logic [CW-1:0]   pc_reg;
    logic [AW-1:0]   base_reg;
    logic [SW-1:0]   size_reg;
    logic [CW-1:0]   fc_reg, fc_next;
    logic [bpfa_pkg::OP_W-1:0] op_reg, op_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [WA_W-1:0] waddr_reg, waddr_next;
    logic [BI_W-1:0] bit_reg, bit_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] end_reg, end_next;
    logic [CW-1:0]   len_reg, len_next;
    logic            mark_reg, mark_next;
    logic [MAP_WORD_BITS-1:0] buf_reg, buf_next;
    logic [PW-1:0]   prod_reg;
    logic [AW-1:0]   res_addr_reg, res_addr_next;
    logic            res_gnt_reg, res_gnt_next;
    logic            res_alc_reg, res_alc_next;

    logic [AW-1:0]   out_addr_reg;
    logic            out_gnt_reg, out_alc_reg, out_valid_reg;
    logic [CW-1:0]   out_fc_reg;

    logic [SW-1:0]   eff_size;
    logic            cfg_fire, in_fire, clr_map;
    logic            div_start, div_done;
    logic [AW-1:0]   div_quo;
    logic            mem_re, mem_we;
    logic [WA_W-1:0] mem_waddr;
    logic [MAP_WORD_BITS-1:0] mem_wdata, mem_rdata;

    logic [CMP_W-1:0] word_base, page_cur, pc_ext, start_v, run_sum, lim;
    logic [MAP_WORD_BITS-1:0] free_mask, mark_mask, new_bits;
    logic [BI_W-1:0] first_free;
    logic [CW-1:0]   pop;

    assign eff_size  = (size_reg == '0) ? SW'(1) : size_reg;
    assign cfg_ready = state_reg == bpfa_pkg::S_IDLE;
    assign in_ready  = state_reg == bpfa_pkg::S_IDLE;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && in_ready;
    assign clr_map   = cfg_fire && (cfg_index == bpfa_pkg::REG_PAGE_COUNT);
    assign div_start = in_fire && addr >= base_reg
                       && (operation == bpfa_pkg::OP_FREE_PAGE
                           || operation == bpfa_pkg::OP_RESERVE
                           || operation == bpfa_pkg::OP_QUERY);

    bpfa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (addr - base_reg),
        .divisor  (eff_size),
        .done     (div_done),
        .quotient (div_quo)
    );

    bpfa_map #(
        .WORDS     (WORDS),
        .WORD_BITS (MAP_WORD_BITS),
        .WA_W      (WA_W)
    ) u_map (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (clr_map),
        .re    (mem_re),
        .raddr (waddr_reg),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign pc_ext    = CMP_W'(pc_reg);
    assign word_base = CMP_W'(waddr_reg) * CMP_W'(MAP_WORD_BITS);
    assign page_cur  = word_base + CMP_W'(bit_reg);
    assign start_v   = (len_reg == '0) ? page_cur : CMP_W'(idx_reg);
    assign run_sum   = CMP_W'(div_quo[IDX_W-1:0]) + CMP_W'(cnt_reg);
    assign lim       = (run_sum > pc_ext) ? pc_ext : run_sum;

    always_comb
    begin
        logic [CMP_W-1:0] pj;
        free_mask  = '0;
        mark_mask  = '0;
        first_free = '0;
        for (int j = 0; j < MAP_WORD_BITS; j++)
        begin
            pj = word_base + CMP_W'(j);
            free_mask[j] = !mem_rdata[j] && (pj < pc_ext);
            mark_mask[j] = (pj >= CMP_W'(idx_reg)) && (pj <= CMP_W'(end_reg));
        end
        for (int j = MAP_WORD_BITS - 1; j >= 0; j--)
        begin
            if (free_mask[j])
            begin
                first_free = BI_W'(j);
            end
        end
    end

    assign new_bits = mark_mask & ~mem_rdata;
    assign pop      = CW'($countones(new_bits));

    always_comb
    begin
        state_next    = state_reg;
        fc_next       = fc_reg;
        op_next       = op_reg;
        cnt_next      = cnt_reg;
        waddr_next    = waddr_reg;
        bit_next      = bit_reg;
        idx_next      = idx_reg;
        end_next      = end_reg;
        len_next      = len_reg;
        mark_next     = mark_reg;
        buf_next      = buf_reg;
        res_addr_next = res_addr_reg;
        res_gnt_next  = res_gnt_reg;
        res_alc_next  = res_alc_reg;
        mem_re        = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = waddr_reg;
        mem_wdata     = mem_rdata;

        case (state_reg)
            bpfa_pkg::S_IDLE:
            begin
                if (clr_map)
                begin
                    fc_next = (cfg_data[CW-1:0] > CW'(MAX_PAGES)) ? CW'(MAX_PAGES)
                                                                 : cfg_data[CW-1:0];
                end
                if (in_fire)
                begin
                    op_next      = operation;
                    cnt_next     = count;
                    waddr_next   = '0;
                    bit_next     = '0;
                    len_next     = '0;
                    mark_next    = 1'b0;
                    res_gnt_next = 1'b0;
                    res_alc_next = 1'b0;
                    res_addr_next = (operation == bpfa_pkg::OP_ALLOC_PAGE
                                     || operation == bpfa_pkg::OP_ALLOC_RUN) ? '1 : '0;
                    state_next   = bpfa_pkg::S_DONE;
                    case (operation)
                        bpfa_pkg::OP_ALLOC_PAGE:
                        begin
                            if (fc_reg != '0)
                            begin
                                state_next = bpfa_pkg::S_RD;
                            end
                        end
                        bpfa_pkg::OP_ALLOC_RUN:
                        begin
                            if (count != '0 && fc_reg >= count)
                            begin
                                state_next = bpfa_pkg::S_RD;
                            end
                        end
                        default:
                        begin
                            if (div_start)
                            begin
                                state_next = bpfa_pkg::S_DIV;
                            end
                        end
                    endcase
                end
            end
            bpfa_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = bpfa_pkg::S_DONE;
                    if (div_quo < AW'(pc_reg)
                        && (op_reg != bpfa_pkg::OP_RESERVE || cnt_reg != '0))
                    begin
                        idx_next   = div_quo[IDX_W-1:0];
                        end_next   = IDX_W'(lim - CMP_W'(1));
                        waddr_next = WA_W'(div_quo[IDX_W-1:0] / MAP_WORD_BITS);
                        bit_next   = BI_W'(div_quo[IDX_W-1:0] % MAP_WORD_BITS);
                        mark_next  = op_reg == bpfa_pkg::OP_RESERVE;
                        state_next = bpfa_pkg::S_RD;
                    end
                end
            end
            bpfa_pkg::S_RD:
            begin
                mem_re     = 1'b1;
                state_next = bpfa_pkg::S_EXAM;
            end
            bpfa_pkg::S_EXAM:
            begin
                state_next = bpfa_pkg::S_DONE;
                if (mark_reg)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata | mark_mask;
                    fc_next   = (fc_reg < pop) ? '0 : fc_reg - pop;
                    if (CMP_W'(waddr_reg) == CMP_W'(end_reg / MAP_WORD_BITS))
                    begin
                        if (op_reg == bpfa_pkg::OP_ALLOC_RUN)
                        begin
                            state_next = bpfa_pkg::S_MUL;
                        end
                    end
                    else
                    begin
                        waddr_next = waddr_reg + 1'b1;
                        state_next = bpfa_pkg::S_RD;
                    end
                end
                else
                begin
                    case (op_reg)
                        bpfa_pkg::OP_ALLOC_PAGE:
                        begin
                            if (free_mask != '0)
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = mem_rdata
                                            | (MAP_WORD_BITS'(1) << first_free);
                                fc_next   = fc_reg - 1'b1;
                                idx_next  = IDX_W'(word_base + CMP_W'(first_free));
                                state_next = bpfa_pkg::S_MUL;
                            end
                            else if (word_base + CMP_W'(MAP_WORD_BITS) < pc_ext)
                            begin
                                waddr_next = waddr_reg + 1'b1;
                                state_next = bpfa_pkg::S_RD;
                            end
                        end
                        bpfa_pkg::OP_ALLOC_RUN:
                        begin
                            buf_next   = mem_rdata;
                            bit_next   = '0;
                            state_next = bpfa_pkg::S_SCAN;
                        end
                        bpfa_pkg::OP_FREE_PAGE:
                        begin
                            if (mem_rdata[bit_reg])
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = mem_rdata
                                            & ~(MAP_WORD_BITS'(1) << bit_reg);
                                fc_next   = fc_reg + 1'b1;
                            end
                        end
                        bpfa_pkg::OP_QUERY:
                        begin
                            res_alc_next = mem_rdata[bit_reg];
                        end
                        default:
                        begin
                            state_next = bpfa_pkg::S_DONE;
                        end
                    endcase
                end
            end
            bpfa_pkg::S_SCAN:
            begin
                if (buf_reg[bit_reg])
                begin
                    len_next = '0;
                end
                else
                begin
                    len_next = len_reg + 1'b1;
                    idx_next = IDX_W'(start_v);
                end
                if (!buf_reg[bit_reg] && len_reg + 1'b1 >= cnt_reg)
                begin
                    end_next   = IDX_W'(start_v + CMP_W'(cnt_reg) - CMP_W'(1));
                    waddr_next = WA_W'(start_v / MAP_WORD_BITS);
                    mark_next  = 1'b1;
                    state_next = bpfa_pkg::S_RD;
                end
                else if (page_cur + CMP_W'(1) >= pc_ext)
                begin
                    state_next = bpfa_pkg::S_DONE;
                end
                else if (CMP_W'(bit_reg) == CMP_W'(MAP_WORD_BITS - 1))
                begin
                    waddr_next = waddr_reg + 1'b1;
                    state_next = bpfa_pkg::S_RD;
                end
                else
                begin
                    bit_next = bit_reg + 1'b1;
                end
            end
            bpfa_pkg::S_MUL:
            begin
                state_next = bpfa_pkg::S_ADD;
            end
            bpfa_pkg::S_ADD:
            begin
                res_addr_next = base_reg + AW'(prod_reg);
                res_gnt_next  = 1'b1;
                state_next    = bpfa_pkg::S_DONE;
            end
            bpfa_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = bpfa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bpfa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpfa_pkg::S_IDLE;
            pc_reg        <= PC_RESET;
            base_reg      <= bpfa_pkg::BASE_RESET;
            size_reg      <= bpfa_pkg::SIZE_RESET;
            fc_reg        <= PC_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fc_reg    <= fc_next;
            if (cfg_fire)
            begin
                case (cfg_index)
                    bpfa_pkg::REG_PAGE_COUNT:
                        pc_reg <= (cfg_data[CW-1:0] > CW'(MAX_PAGES)) ? CW'(MAX_PAGES)
                                                                     : cfg_data[CW-1:0];
                    bpfa_pkg::REG_BASE_ADDR:
                        base_reg <= cfg_data;
                    bpfa_pkg::REG_PAGE_SIZE:
                        size_reg <= cfg_data[SW-1:0];
                    default:
                        base_reg <= base_reg;
                endcase
            end
            if (state_reg == bpfa_pkg::S_DONE && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        cnt_reg      <= cnt_next;
        waddr_reg    <= waddr_next;
        bit_reg      <= bit_next;
        idx_reg      <= idx_next;
        end_reg      <= end_next;
        len_reg      <= len_next;
        mark_reg     <= mark_next;
        buf_reg      <= buf_next;
        res_addr_reg <= res_addr_next;
        res_gnt_reg  <= res_gnt_next;
        res_alc_reg  <= res_alc_next;
        prod_reg     <= PW'(idx_reg) * PW'(eff_size);
        if (state_reg == bpfa_pkg::S_DONE && (!out_valid_reg || out_ready))
        begin
            out_addr_reg <= res_addr_reg;
            out_gnt_reg  <= res_gnt_reg;
            out_alc_reg  <= res_alc_reg;
            out_fc_reg   <= fc_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign page_address = out_addr_reg;
    assign granted      = out_gnt_reg;
    assign allocated    = out_alc_reg;
    assign free_left    = out_fc_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg != bpfa_pkg::S_IDLE)
        else $error("request accepted but controller stayed idle");

    a_free_le_pages: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= pc_reg)
        else $error("free count above page count");

    a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_re && mem_we))
        else $error("map read and write in the same cycle");

    a_clear_sets_count: assert property (@(posedge clk) disable iff (!rst_n)
        clr_map |=> fc_reg == pc_reg)
        else $error("page count write did not reload free count");

endmodule

### rtl/bpfa_div.sv
module bpfa_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bpfa_pkg::ADDR_W-1:0] dividend,
    input  logic [bpfa_pkg::SIZE_W-1:0] divisor,
    output logic                        done,
    output logic [bpfa_pkg::ADDR_W-1:0] quotient
);

    localparam int N  = bpfa_pkg::ADDR_W;
    localparam int D  = bpfa_pkg::SIZE_W;
    localparam int CW = $clog2(N + 1);

    logic [N-1:0]  quo_reg;
    logic [D-1:0]  rem_reg;
    logic [D-1:0]  div_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [D:0]    rem_sh;
    logic          ge;
    logic [D:0]    rem_sub;

    assign rem_sh  = {rem_reg, quo_reg[N-1]};
    assign ge      = rem_sh >= {1'b0, div_reg};
    assign rem_sub = rem_sh - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(N);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[N-2:0], ge};
            rem_reg <= ge ? rem_sub[D-1:0] : rem_sh[D-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/bpfa_map.sv
module bpfa_map #(
    parameter int WORDS     = 128,
    parameter int WORD_BITS = 32,
    parameter int WA_W      = 7
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clr,
    input  logic                 re,
    input  logic [WA_W-1:0]      raddr,
    input  logic                 we,
    input  logic [WA_W-1:0]      waddr,
    input  logic [WORD_BITS-1:0] wdata,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORDS-1:0]     vld_reg;
    logic [WORD_BITS-1:0] rd_reg;
    logic                 rv_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            rv_reg  <= 1'b0;
        end
        else
        begin
            if (re)
            begin
                rv_reg <= vld_reg[raddr];
            end
            if (clr)
            begin
                vld_reg <= '0;
            end
            else if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
        end
    end

    assign rdata = rv_reg ? rd_reg : '0;

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int ADDR_W = bpfa_pkg::ADDR_W;
    localparam int SIZE_W = bpfa_pkg::SIZE_W;
    localparam int CNT_W  = bpfa_pkg::CNT_W;
    localparam int OP_W   = bpfa_pkg::OP_W;
    localparam int CFG_W  = bpfa_pkg::CFG_W;

    localparam logic [CFG_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [OP_W-1:0]  OP_BAD_LO  = 3'd5;
    localparam logic [OP_W-1:0]  OP_BAD_HI  = 3'd7;
    localparam logic [ADDR_W-1:0] ALL_ONES  = '1;
    localparam int PAGES_MAX = 4096;

    typedef struct {
        logic [ADDR_W-1:0] page_address;
        logic              granted;
        logic              allocated;
        logic [CNT_W-1:0]  free_left;
    } grant_t;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] a;
        logic [CNT_W-1:0]  n;
        bit                known;
        grant_t            res;
    } stim_row_t;

    typedef struct {
        int unsigned       pages;
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] psize;
        int                items;
    } phase_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_W-1:0] cfg_index;
    logic [ADDR_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [OP_W-1:0] operation;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0] count;
    logic out_valid;
    logic out_ready;
    logic [ADDR_W-1:0] page_address;
    logic granted;
    logic allocated;
    logic [CNT_W-1:0] free_left;

    // allocator shadow state
    bit                frame_used [PAGES_MAX];
    int unsigned       frames_free;
    int unsigned       frames_total;
    logic [ADDR_W-1:0] frame_base;
    logic [SIZE_W-1:0] frame_size;

    grant_t pending_grants[$];
    int     mismatches;
    int     results_seen;
    bit     no_idle;

    bitmap_page_frame_allocator_unit uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .addr(addr), .count(count),
        .out_valid(out_valid), .out_ready(out_ready),
        .page_address(page_address), .granted(granted),
        .allocated(allocated), .free_left(free_left)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [ADDR_W-1:0] eff_size();
        return (frame_size == 0) ? 64'd1 : {32'd0, frame_size};
    endfunction

    function automatic void clear_frames(int unsigned n);
        frames_total = (n > PAGES_MAX) ? PAGES_MAX : n;
        frames_free = frames_total;
        foreach (frame_used[i]) frame_used[i] = 1'b0;
    endfunction

    function automatic void apply_register(logic [CFG_W-1:0] idx, logic [ADDR_W-1:0] val);
        if (idx == bpfa_pkg::REG_PAGE_COUNT) clear_frames(32'(val[CNT_W-1:0]));
        else if (idx == bpfa_pkg::REG_BASE_ADDR) frame_base = val;
        else if (idx == bpfa_pkg::REG_PAGE_SIZE) frame_size = val[SIZE_W-1:0];
    endfunction

    function automatic bit page_index(logic [ADDR_W-1:0] a, output logic [ADDR_W-1:0] idx);
        idx = 0;
        if (a < frame_base) return 0;
        idx = (a - frame_base) / eff_size();
        return 1;
    endfunction

    function automatic grant_t allocate_frames(logic [OP_W-1:0] op, logic [ADDR_W-1:0] a,
                                               logic [CNT_W-1:0] n);
        grant_t r;
        logic [ADDR_W-1:0] idx;
        int unsigned start;
        int unsigned len;
        r.page_address = 0;
        r.granted = 0;
        r.allocated = 0;
        start = 0;
        len = 0;
        case (op)
            bpfa_pkg::OP_ALLOC_PAGE:
            begin
                r.page_address = ALL_ONES;
                for (int i = 0; i < frames_total && frames_free != 0; i++)
                    if (!frame_used[i])
                    begin
                        frame_used[i] = 1'b1;
                        frames_free--;
                        r.page_address = frame_base + 64'(i) * eff_size();
                        r.granted = 1;
                        break;
                    end
            end
            bpfa_pkg::OP_ALLOC_RUN:
            begin
                r.page_address = ALL_ONES;
                if (n != 0 && frames_free >= n)
                    for (int i = 0; i < frames_total; i++)
                    begin
                        if (frame_used[i])
                        begin
                            len = 0;
                            continue;
                        end
                        if (len == 0) start = i;
                        len++;
                        if (len >= n)
                        begin
                            for (int k = 0; k < n; k++) frame_used[start + k] = 1'b1;
                            frames_free -= n;
                            r.page_address = frame_base + 64'(start) * eff_size();
                            r.granted = 1;
                            break;
                        end
                    end
            end
            bpfa_pkg::OP_FREE_PAGE:
                if (page_index(a, idx) && idx < frames_total && frame_used[idx])
                begin
                    frame_used[idx] = 1'b0;
                    frames_free++;
                end
            bpfa_pkg::OP_RESERVE:
                if (page_index(a, idx))
                    for (int i = 0; i < n && idx + i < frames_total; i++)
                        if (!frame_used[idx + i])
                        begin
                            frame_used[idx + i] = 1'b1;
                            if (frames_free != 0) frames_free--;
                        end
            bpfa_pkg::OP_QUERY:
                if (page_index(a, idx) && idx < frames_total && frame_used[idx])
                    r.allocated = 1;
            default: ;
        endcase
        r.free_left = CNT_W'(frames_free);
        return r;
    endfunction

    task automatic write_register(logic [CFG_W-1:0] idx, logic [ADDR_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_register(idx, val);
    endtask

    task automatic drain();
        while (pending_grants.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic send_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] a,
                                logic [CNT_W-1:0] n, bit known, grant_t lit);
        grant_t r;
        if (!no_idle && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        addr <= a;
        count <= n;
        do @(posedge clk); while (!in_ready);
        r = allocate_frames(op, a, n);
        pending_grants.push_back(known ? lit : r);
    endtask

    function automatic logic [ADDR_W-1:0] pick_addr();
        logic [ADDR_W-1:0] ofs;
        int unsigned k;
        k = $urandom_range(9);
        ofs = (eff_size() > 1) ? 64'($urandom_range(0, 32'(eff_size() - 1))) : 64'd0;
        if (k == 0) return {$urandom, $urandom};
        if (k == 1 && frame_base != 0) return frame_base - 64'($urandom_range(1, 1000));
        return frame_base + 64'($urandom_range(0, frames_total + 3)) * eff_size() + ofs;
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        int unsigned k;
        k = $urandom_range(19);
        if (k == 0) return CNT_W'($urandom);
        if (k < 3) return CNT_W'($urandom_range(0, frames_total + 2));
        return CNT_W'($urandom_range(0, 6));
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 22) return bpfa_pkg::OP_ALLOC_PAGE;
        if (k < 40) return bpfa_pkg::OP_ALLOC_RUN;
        if (k < 62) return bpfa_pkg::OP_FREE_PAGE;
        if (k < 72) return bpfa_pkg::OP_RESERVE;
        if (k < 94) return bpfa_pkg::OP_QUERY;
        return OP_W'($urandom_range(32'(OP_BAD_LO), 32'(OP_BAD_HI)));
    endfunction

    // result side: checking, random stalls and one long hold-off
    initial
    begin
        int hold;
        grant_t e;
        hold = 0;
        out_ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_grants.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: addr %h g %b a %b free %0d",
                                 page_address, granted, allocated, free_left);
                end
                else
                begin
                    e = pending_grants.pop_front();
                    if (page_address !== e.page_address || granted !== e.granted ||
                        allocated !== e.allocated || free_left !== e.free_left)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp addr %h g %b a %b free %0d,",
                                      " got addr %h g %b a %b free %0d"},
                                     e.page_address, e.granted, e.allocated, e.free_left,
                                     page_address, granted, allocated, free_left);
                    end
                end
                if (results_seen == 250) hold = 400;
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= no_idle || $urandom_range(99) >= 18;
        end
    end

    initial
    begin
        #500ms;
        $display("** bitmap_page_frame_allocator_unit: FAILED **");
        $finish;
    end

    initial
    begin
        stim_row_t rows[$];
        phase_t phases[$];
        grant_t none;
        none = '{0, 0, 0, 0};
        rst_n = 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= bpfa_pkg::REG_PAGE_COUNT;
        cfg_data <= 0;
        in_valid <= 1'b0;
        operation <= bpfa_pkg::OP_ALLOC_PAGE;
        addr <= 0;
        count <= 0;
        mismatches = 0;
        results_seen = 0;
        no_idle = 0;
        frame_base = bpfa_pkg::BASE_RESET;
        frame_size = bpfa_pkg::SIZE_RESET;
        clear_frames(32'(bpfa_pkg::PAGE_COUNT_RESET));
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = '{
            '{bpfa_pkg::OP_ALLOC_PAGE, 64'h0,      13'd0,    1, '{64'h0, 1, 0, 13'd4095}},
            '{bpfa_pkg::OP_QUERY,      64'h0,      13'd0,    1, '{64'h0, 0, 1, 13'd4095}},
            '{bpfa_pkg::OP_QUERY,      64'h1000,   13'd0,    1, '{64'h0, 0, 0, 13'd4095}},
            '{bpfa_pkg::OP_FREE_PAGE,  64'h5,      13'd0,    1, '{64'h0, 0, 0, 13'd4096}},
            '{bpfa_pkg::OP_FREE_PAGE,  64'h5,      13'd0,    1, '{64'h0, 0, 0, 13'd4096}},
            '{bpfa_pkg::OP_ALLOC_RUN,  64'h0,      13'd0,    1, '{ALL_ONES, 0, 0, 13'd4096}},
            '{bpfa_pkg::OP_ALLOC_RUN,  64'h0,      13'd8191, 1, '{ALL_ONES, 0, 0, 13'd4096}},
            '{bpfa_pkg::OP_ALLOC_RUN,  ALL_ONES,   13'd4096, 1, '{64'h0, 1, 0, 13'd0}},
            '{bpfa_pkg::OP_ALLOC_PAGE, 64'h0,      13'd0,    1, '{ALL_ONES, 0, 0, 13'd0}},
            '{bpfa_pkg::OP_QUERY,      ALL_ONES,   13'd0,    1, '{64'h0, 0, 0, 13'd0}},
            '{bpfa_pkg::OP_FREE_PAGE,  ALL_ONES,   13'd0,    1, '{64'h0, 0, 0, 13'd0}},
            '{bpfa_pkg::OP_FREE_PAGE,  64'hFFF000, 13'd0,    1, '{64'h0, 0, 0, 13'd1}},
            '{bpfa_pkg::OP_ALLOC_PAGE, 64'h0,      13'd0,    1, '{64'hFFF000, 1, 0, 13'd0}},
            '{OP_BAD_LO,               ALL_ONES,   13'd8191, 1, '{64'h0, 0, 0, 13'd0}},
            '{OP_BAD_HI,               64'h0,      13'd0,    1, '{64'h0, 0, 0, 13'd0}},
            '{bpfa_pkg::OP_FREE_PAGE,  64'h1000,   13'd0,    0, none},
            '{bpfa_pkg::OP_FREE_PAGE,  64'h3FFF,   13'd0,    0, none},
            '{bpfa_pkg::OP_FREE_PAGE,  64'h5000,   13'd0,    0, none},
            '{bpfa_pkg::OP_ALLOC_RUN,  64'h0,      13'd2,    0, none},
            '{bpfa_pkg::OP_RESERVE,    64'h1234,   13'd5,    0, none},
            '{bpfa_pkg::OP_RESERVE,    64'hFFE000, 13'd8191, 0, none},
            '{bpfa_pkg::OP_QUERY,      64'h3000,   13'd0,    0, none},
            '{bpfa_pkg::OP_RESERVE,    64'h0,      13'd0,    0, none},
            '{bpfa_pkg::OP_ALLOC_PAGE, 64'h0,      13'd0,    0, none}
        };
        foreach (rows[i])
            send_request(rows[i].op, rows[i].a, rows[i].n, rows[i].known, rows[i].res);
        in_valid <= 1'b0;
        drain();

        write_register(REG_UNUSED, ALL_ONES);
        phases = '{
            '{8191, 64'hFFFF_FFFF_FFFF_0000, 32'd0,          40},
            '{0,    64'h0,                   32'd1,          30},
            '{64,   {32'h1234_5678, 32'h9ABC_0000}, 32'd4096, 300},
            '{100,  64'h8000_0000_0000_0000, 32'hFFFF_FFFF, 300},
            '{200,  64'h0000_00FF_0000_0000, 32'd512,       400},
            '{37,   64'd123,                 32'd3,         300},
            '{4096, 64'h0,                   32'd4096,      60},
            '{150,  64'hFFFF_FFFF_FFFF_F000, 32'd16,        120}
        };
        foreach (phases[p])
        begin
            write_register(bpfa_pkg::REG_BASE_ADDR, phases[p].base);
            write_register(bpfa_pkg::REG_PAGE_SIZE, 64'(phases[p].psize));
            write_register(bpfa_pkg::REG_PAGE_COUNT, 64'(phases[p].pages));
            no_idle = (p == 4);
            for (int i = 0; i < phases[p].items; i++)
            begin
                if (p == 2 && i == 150)
                begin
                    in_valid <= 1'b0;
                    drain();
                end
                send_request(pick_op(), pick_addr(), pick_count(), 0, none);
            end
            in_valid <= 1'b0;
            drain();
        end
        no_idle = 0;

        repeat (50) @(posedge clk);
        if (mismatches == 0 && pending_grants.size() == 0)
            $display("** bitmap_page_frame_allocator_unit: PASSED **");
        else
            $display("** bitmap_page_frame_allocator_unit: FAILED **");
        $finish;
    end
endmodule
